FILE: design/bqc_pkg.sv
// Package for the two-stage biquad cascade: widths, codes, control word types
// and the microcode table that sequences the shared multiply-accumulate.
// No dependencies.
`default_nettype none

package bqc_pkg;

    localparam int SAMPLE_WIDTH_DEF        = 16;
    localparam int COEFF_FRACTION_BITS_DEF = 14;
    localparam int COEFF_BITS              = 16;
    localparam int NUM_STAGES              = 2;
    localparam int STAGE_W                 = 1;
    localparam int STEP_W                  = 4;
    localparam int FF_W                    = 48;
    localparam int FB_W                    = 32;
    localparam int CFG_DATA_W              = 48;
    localparam int CFG_INDEX_W             = 2;

    localparam logic [FF_W-1:0] FF_RESET = FF_W'(16384);
    localparam logic [FB_W-1:0] FB_RESET = '0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_S0_FF = 2'd0,
        CFG_S0_FB = 2'd1,
        CFG_S1_FF = 2'd2,
        CFG_S1_FB = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        SRC_X,
        SRC_X1,
        SRC_X2,
        SRC_Y1,
        SRC_Y2
    } t_src;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic               wait_in;
        logic               mul_en;
        t_src               src;
        logic [STAGE_W-1:0] mul_stage;
        t_acc_op            acc_op;
        logic               fin;
        logic [STAGE_W-1:0] fin_stage;
        logic               emit;
        logic               last;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   go;
    } t_ctrl;

    function automatic t_uword mul_word(t_src src, logic [STAGE_W-1:0] stage,
                                        t_acc_op acc_op);
        t_uword w;
        w           = '0;
        w.mul_en    = 1'b1;
        w.src       = src;
        w.mul_stage = stage;
        w.acc_op    = acc_op;
        return w;
    endfunction

    function automatic t_uword ucode(logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        case (step)
            4'd0:  w.wait_in = 1'b1;
            4'd1:  w = mul_word(SRC_X,  1'b0, ACC_HOLD);
            4'd2:  w = mul_word(SRC_X1, 1'b0, ACC_LOAD);
            4'd3:  w = mul_word(SRC_X2, 1'b0, ACC_ADD);
            4'd4:  w = mul_word(SRC_Y1, 1'b0, ACC_ADD);
            4'd5:  w = mul_word(SRC_Y2, 1'b0, ACC_ADD);
            4'd6: begin
                w           = mul_word(SRC_Y1, 1'b1, ACC_HOLD);
                w.fin       = 1'b1;
                w.fin_stage = 1'b0;
            end
            4'd7:  w = mul_word(SRC_Y2, 1'b1, ACC_LOAD);
            4'd8:  w = mul_word(SRC_X,  1'b1, ACC_ADD);
            4'd9:  w = mul_word(SRC_X1, 1'b1, ACC_ADD);
            4'd10: w = mul_word(SRC_X2, 1'b1, ACC_ADD);
            4'd11: begin
                w.fin       = 1'b1;
                w.fin_stage = 1'b1;
                w.emit      = 1'b1;
                w.last      = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: design/bqc_stream_if.sv
// Valid/ready stream interfaces for the input and output sample words.
// Depends on bqc_pkg for the default sample width.
`default_nettype none

interface bqc_in_if #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if #(
    parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: design/bqc_sequencer.sv
// Step counter and microcode fetch for the biquad cascade.
// Depends on bqc_pkg for the control word and the microcode table.
`default_nettype none

module bqc_sequencer (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_busy,
    output bqc_pkg::t_ctrl      o_ctrl
);

    logic [bqc_pkg::STEP_W-1:0] r_step;
    logic [bqc_pkg::STEP_W-1:0] n_step;
    bqc_pkg::t_uword            w_uw;
    logic                       w_go;

    always_comb begin
        w_uw = bqc_pkg::ucode(r_step);
        // hold on the wait step until a word arrives; hold on emit while output is full
        w_go = !(w_uw.wait_in && !i_in_valid) && !(w_uw.emit && i_out_busy);
        n_step = r_step;
        if (w_go) begin
            if (w_uw.last) begin
                n_step = '0;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
        o_ctrl.uw = w_uw;
        o_ctrl.go = w_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

FILE: design/bqc_datapath.sv
// Shared multiplier, accumulator, round/saturate, per-stage histories and
// output register of the biquad cascade. Depends on bqc_pkg.
`default_nettype none

module bqc_datapath #(
    parameter int SAMPLE_WIDTH        = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRACTION_BITS = bqc_pkg::COEFF_FRACTION_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bqc_pkg::t_ctrl                  i_ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire logic [bqc_pkg::FF_W-1:0]        i_ff0,
    input  wire logic [bqc_pkg::FB_W-1:0]        i_fb0,
    input  wire logic [bqc_pkg::FF_W-1:0]        i_ff1,
    input  wire logic [bqc_pkg::FB_W-1:0]        i_fb1,
    input  wire logic                            i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [SAMPLE_WIDTH-1:0]       o_out_sample,
    output logic                                 o_out_busy
);

    localparam int CB     = bqc_pkg::COEFF_BITS;
    localparam int PROD_W = SAMPLE_WIDTH + CB;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) <<< (COEFF_FRACTION_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(1) <<< (SAMPLE_WIDTH - 1));

    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_x1 [bqc_pkg::NUM_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_x2 [bqc_pkg::NUM_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_y1 [bqc_pkg::NUM_STAGES];
    logic signed [SAMPLE_WIDTH-1:0] r_y2 [bqc_pkg::NUM_STAGES];
    logic signed [PROD_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]        r_acc;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_sample;

    bqc_pkg::t_uword                w_uw;
    logic [bqc_pkg::FF_W-1:0]       w_ff;
    logic [bqc_pkg::FB_W-1:0]       w_fb;
    logic signed [CB-1:0]           w_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_opnd;
    logic signed [PROD_W-1:0]       w_prod;
    logic signed [ACC_W-1:0]        w_prod_ext;
    logic signed [ACC_W-1:0]        w_sum;
    logic signed [ACC_W-1:0]        w_shift;
    logic signed [SAMPLE_WIDTH-1:0] w_y;
    logic                           w_load_out;

    always_comb begin
        w_uw = i_ctrl.uw;
        w_ff = (w_uw.mul_stage == 1'b0) ? i_ff0 : i_ff1;
        w_fb = (w_uw.mul_stage == 1'b0) ? i_fb0 : i_fb1;
        case (w_uw.src)
            bqc_pkg::SRC_X: begin
                w_coef = w_ff[15:0];
                w_opnd = r_x;
            end
            bqc_pkg::SRC_X1: begin
                w_coef = w_ff[31:16];
                w_opnd = r_x1[w_uw.mul_stage];
            end
            bqc_pkg::SRC_X2: begin
                w_coef = w_ff[47:32];
                w_opnd = r_x2[w_uw.mul_stage];
            end
            bqc_pkg::SRC_Y1: begin
                w_coef = w_fb[15:0];
                w_opnd = r_y1[w_uw.mul_stage];
            end
            bqc_pkg::SRC_Y2: begin
                w_coef = w_fb[31:16];
                w_opnd = r_y2[w_uw.mul_stage];
            end
            default: begin
                w_coef = '0;
                w_opnd = '0;
            end
        endcase
        w_prod     = PROD_W'(w_opnd) * PROD_W'(w_coef);
        w_prod_ext = ACC_W'(r_prod);
        w_sum      = r_acc + w_prod_ext;
        w_shift    = w_sum >>> COEFF_FRACTION_BITS;
        if (w_shift > SAT_MAX) begin
            w_y = SAT_MAX[SAMPLE_WIDTH-1:0];
        end else if (w_shift < SAT_MIN) begin
            w_y = SAT_MIN[SAMPLE_WIDTH-1:0];
        end else begin
            w_y = w_shift[SAMPLE_WIDTH-1:0];
        end
        w_load_out = i_ctrl.go && w_uw.fin && w_uw.emit;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.go && w_uw.wait_in) begin
            r_x <= i_sample;
        end else if (i_ctrl.go && w_uw.fin) begin
            r_x <= w_y;
        end
        if (i_ctrl.go && w_uw.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.go) begin
            case (w_uw.acc_op)
                bqc_pkg::ACC_LOAD: r_acc <= w_prod_ext + ROUND_HALF;
                bqc_pkg::ACC_ADD:  r_acc <= w_sum;
                default:           r_acc <= r_acc;
            endcase
        end
        if (w_load_out) begin
            r_out_sample <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < bqc_pkg::NUM_STAGES; s++) begin
                r_x1[s] <= '0;
                r_x2[s] <= '0;
                r_y1[s] <= '0;
                r_y2[s] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.go && w_uw.fin) begin
                r_x2[w_uw.fin_stage] <= r_x1[w_uw.fin_stage];
                r_x1[w_uw.fin_stage] <= r_x;
                r_y2[w_uw.fin_stage] <= r_y1[w_uw.fin_stage];
                r_y1[w_uw.fin_stage] <= w_y;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_out_busy   = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

FILE: design/biquad_cascade_filter.sv
// Two cascaded direct-form-I biquads on signed samples. Each stage forms
// b0*x + b1*x1 + b2*x2 + a1*y1 + a2*y2 with Q2.14 coefficients (a1, a2 carry
// their sign, since the feedback terms are added), rounds half up, saturates
// to the sample range and keeps the saturated value as its output history.
// One multiplier is shared by all ten products under a twelve-step microcode
// program, so a new word is taken only once the previous one has run through
// every step, and later still while a finished result waits in the output
// register. Coefficient registers (index 0..3: stage 0 b, stage 0 a, stage 1
// b, stage 1 a) are written through the configuration port; the user must
// write them only while the filter is idle, as the block does not enforce it.
// Depends on bqc_pkg, bqc_stream_if, bqc_sequencer and bqc_datapath.
`default_nettype none

module biquad_cascade_filter #(
    parameter int SAMPLE_WIDTH        = bqc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRACTION_BITS = bqc_pkg::COEFF_FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    bqc_in_if.sink                                  i_in,
    bqc_out_if.source                               o_out,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [bqc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [bqc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [bqc_pkg::FF_W-1:0] r_ff0;
    logic [bqc_pkg::FB_W-1:0] r_fb0;
    logic [bqc_pkg::FF_W-1:0] r_ff1;
    logic [bqc_pkg::FB_W-1:0] r_fb1;

    bqc_pkg::t_ctrl w_ctrl;
    logic           w_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0 <= bqc_pkg::FF_RESET;
            r_fb0 <= bqc_pkg::FB_RESET;
            r_ff1 <= bqc_pkg::FF_RESET;
            r_fb1 <= bqc_pkg::FB_RESET;
        end else if (i_cfg_wr_en) begin
            case (bqc_pkg::t_cfg_index'(i_cfg_index))
                bqc_pkg::CFG_S0_FF: r_ff0 <= i_cfg_wdata[bqc_pkg::FF_W-1:0];
                bqc_pkg::CFG_S0_FB: r_fb0 <= i_cfg_wdata[bqc_pkg::FB_W-1:0];
                bqc_pkg::CFG_S1_FF: r_ff1 <= i_cfg_wdata[bqc_pkg::FF_W-1:0];
                bqc_pkg::CFG_S1_FB: r_fb1 <= i_cfg_wdata[bqc_pkg::FB_W-1:0];
                default: ;
            endcase
        end
    end

    bqc_sequencer u_sequencer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_busy (w_out_busy),
        .o_ctrl     (w_ctrl)
    );

    bqc_datapath #(
        .SAMPLE_WIDTH        (SAMPLE_WIDTH),
        .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_sample     (i_in.sample_in),
        .i_ff0        (r_ff0),
        .i_fb0        (r_fb0),
        .i_ff1        (r_ff1),
        .i_fb1        (r_fb1),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_sample (o_out.sample_out),
        .o_out_busy   (w_out_busy)
    );

    assign i_in.ready = w_ctrl.uw.wait_in;

endmodule

`default_nettype wire

FILE: design/bqc_checker.sv
// Port-level checks for the biquad cascade, bound to the top level.
// Depends on biquad_cascade_filter port names only.
`default_nettype none

module bqc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready ##10 !i_in_ready)
        else $error("input taken while a word is in flight");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 12))
        else $error("result without matching input word");

endmodule

bind biquad_cascade_filter bqc_checker u_bqc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire

FILE: tb/sv/biquad_cascade_filter_test.sv
// Self-checking bench for the two-stage biquad cascade: drives sample words and
// coefficient writes, predicts every filtered word and checks it on arrival.
// Depends on bqc_pkg, the bqc stream interfaces and biquad_cascade_filter.
`timescale 1ns / 100ps

module biquad_cascade_filter_test;
    import bqc_pkg::*;

    typedef logic signed [SAMPLE_WIDTH_DEF-1:0] sample_t;
    typedef logic signed [COEFF_BITS-1:0]       coeff_t;

    localparam int     FRAC       = COEFF_FRACTION_BITS_DEF;
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH_DEF - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    class cascade_tracker;
        coeff_t  ff_coeff [NUM_STAGES][3];
        coeff_t  fb_coeff [NUM_STAGES][2];
        sample_t x_d1 [NUM_STAGES];
        sample_t x_d2 [NUM_STAGES];
        sample_t y_d1 [NUM_STAGES];
        sample_t y_d2 [NUM_STAGES];
        sample_t predicted_samples [$];
        int      mismatches;

        function new();
            mismatches = 0;
            for (int s = 0; s < NUM_STAGES; s++) begin
                for (int k = 0; k < 3; k++) ff_coeff[s][k] = coeff_t'(FF_RESET[16*k +: 16]);
                for (int k = 0; k < 2; k++) fb_coeff[s][k] = coeff_t'(FB_RESET[16*k +: 16]);
                x_d1[s] = '0;
                x_d2[s] = '0;
                y_d1[s] = '0;
                y_d2[s] = '0;
            end
        endfunction

        function void load_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
            int s;
            s = (idx == CFG_S1_FF || idx == CFG_S1_FB) ? 1 : 0;
            case (idx)
                CFG_S0_FF, CFG_S1_FF: begin
                    for (int k = 0; k < 3; k++) ff_coeff[s][k] = coeff_t'(data[16*k +: 16]);
                end
                default: begin
                    for (int k = 0; k < 2; k++) fb_coeff[s][k] = coeff_t'(data[16*k +: 16]);
                end
            endcase
        endfunction

        function sample_t filter_stage(int s, sample_t x);
            longint  acc;
            longint  q;
            sample_t y;
            acc = longint'(x) * longint'(ff_coeff[s][0])
                + longint'(x_d1[s]) * longint'(ff_coeff[s][1])
                + longint'(x_d2[s]) * longint'(ff_coeff[s][2])
                + longint'(y_d1[s]) * longint'(fb_coeff[s][0])
                + longint'(y_d2[s]) * longint'(fb_coeff[s][1]);
            q = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
            if (q > SAMPLE_MAX) y = sample_t'(SAMPLE_MAX);
            else if (q < SAMPLE_MIN) y = sample_t'(SAMPLE_MIN);
            else y = sample_t'(q);
            x_d2[s] = x_d1[s];
            x_d1[s] = x;
            y_d2[s] = y_d1[s];
            y_d1[s] = y;
            return y;
        endfunction

        function void note_sample(sample_t x);
            sample_t v;
            v = x;
            for (int s = 0; s < NUM_STAGES; s++) v = filter_stage(s, v);
            predicted_samples.push_back(v);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_sample(sample_t got);
            sample_t want;
            if (predicted_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected word sample_out=%0d", got));
            end else begin
                want = predicted_samples.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("sample_out=%0d, predicted %0d", got, want));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    bit                     src_gaps;
    bit                     sink_stalls;
    cascade_tracker         tracker;

    bqc_in_if  in_ch ();
    bqc_out_if out_ch ();

    biquad_cascade_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stalls && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) tracker.check_sample(out_ch.sample_out);
    end

    function automatic int pick_gap();
        if (src_gaps && $urandom_range(0, 3) == 0) return $urandom_range(1, 8);
        return 0;
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
            1: return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coeff_t random_coeff(bit gentle, int span);
        if (gentle) return coeff_t'(int'($urandom_range(0, 2 * span)) - span);
        return coeff_t'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_ff(bit gentle);
        return {random_coeff(gentle, 12000), random_coeff(gentle, 12000),
                random_coeff(gentle, 16384)};
    endfunction

    // upper word of a feedback write lies beyond the register and must be dropped
    function automatic logic [CFG_DATA_W-1:0] random_fb(bit gentle);
        return {16'($urandom), random_coeff(gentle, 5000), random_coeff(gentle, 6000)};
    endfunction

    task automatic send_sample(sample_t x, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.note_sample(x);
    endtask

    task automatic drain_filter();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.predicted_samples.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.load_register(idx, data);
    endtask

    task automatic program_filter(logic [CFG_DATA_W-1:0] ff0, logic [CFG_DATA_W-1:0] fb0,
                                  logic [CFG_DATA_W-1:0] ff1, logic [CFG_DATA_W-1:0] fb1);
        drain_filter();
        write_reg(CFG_S0_FF, ff0);
        write_reg(CFG_S0_FB, fb0);
        write_reg(CFG_S1_FF, ff1);
        write_reg(CFG_S1_FB, fb1);
    endtask

    initial begin
        sample_t passthru [$];
        sample_t halves [$];
        sample_t pushes [$];
        sample_t pulls [$];
        passthru = '{32767, -32768, 0, -1, 1, 16'sh5555, 16'shAAAA};
        halves   = '{1, -1, 3, -3};
        pushes   = '{32767, 32767, 32767, -32768, -32768, -32768, 0, 0};
        pulls    = '{32767, -32768, 0};

        tracker         = new();
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        src_gaps        = 1'b1;
        sink_stalls     = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (passthru[i]) send_sample(passthru[i], pick_gap());

        program_filter(48'd8192, 48'h0, 48'd16384, 48'h0);
        foreach (halves[i]) send_sample(halves[i], pick_gap());

        program_filter({3{16'h7FFF}}, {16'hBEEF, 16'h8000, 16'h8000},
                       {3{16'h7FFF}}, {16'h1234, 16'h8000, 16'h8000});
        foreach (pushes[i]) send_sample(pushes[i], pick_gap());

        program_filter({3{16'h8000}}, {16'hFFFF, 16'h7FFF, 16'h7FFF},
                       {3{16'h8000}}, {16'h0000, 16'h7FFF, 16'h7FFF});
        foreach (pulls[i]) send_sample(pulls[i], pick_gap());

        for (int p = 0; p < 8; p++) begin
            src_gaps    = (p != 7) && (p % 3 != 2);
            sink_stalls = (p != 7) && (p % 4 != 3);
            program_filter(random_ff(p % 2 == 1), random_fb(p % 2 == 1),
                           random_ff(p % 2 == 1), random_fb(p % 2 == 1));
            repeat (150) send_sample(random_sample(), pick_gap());
        end

        drain_filter();
        repeat (8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.predicted_samples.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/bqc_pkg.sv
design/bqc_stream_if.sv
design/bqc_sequencer.sv
design/bqc_datapath.sv
design/biquad_cascade_filter.sv
design/bqc_checker.sv
tb/sv/biquad_cascade_filter_test.sv
